### src/ctf_pkg.sv
// Shared constants, register codes and the arctangent table of the tilt filter.
package ctf_pkg;

  typedef enum logic [2:0] {
    REG_BLEND_WEIGHT  = 3'd0,
    REG_ROLL_OFFSET   = 3'd1,
    REG_PITCH_OFFSET  = 3'd2,
    REG_RATE_BIAS_X   = 3'd3,
    REG_RATE_BIAS_Y   = 3'd4,
    REG_RATE_BIAS_Z   = 3'd5
  } cfg_reg_t;

  localparam logic [15:0] BLEND_WEIGHT_RESET = 16'd62915;
  localparam int          ATAN_MAX_STEPS     = 24;

  typedef logic signed [25:0] tilt_angle_t;
  typedef logic signed [33:0] angle_inc_t;

  // atan(2^-i) in degrees Q16.16, rounded to nearest
  function automatic logic signed [25:0] atan_entry(logic [4:0] idx);
    logic signed [25:0] v;
    case (idx)
      5'd0:  v = 26'sd2949120;
      5'd1:  v = 26'sd1740967;
      5'd2:  v = 26'sd919879;
      5'd3:  v = 26'sd466945;
      5'd4:  v = 26'sd234379;
      5'd5:  v = 26'sd117304;
      5'd6:  v = 26'sd58666;
      5'd7:  v = 26'sd29335;
      5'd8:  v = 26'sd14668;
      5'd9:  v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      5'd20: v = 26'sd4;
      5'd21: v = 26'sd2;
      5'd22: v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

endpackage

### src/ctf_in_if.sv
// Input sample channel: raw accelerometer, gyro and interval.
interface ctf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  logic signed [15:0] rate_z;
  logic        [15:0] delta_ms;

  modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, delta_ms,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, delta_ms,
                output ready);
endinterface

### src/ctf_out_if.sv
// Result channel: filtered roll, pitch and integrated yaw.
interface ctf_out_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] roll_deg;
  logic signed [24:0] pitch_deg;
  logic signed [31:0] yaw_deg;

  modport source (output valid, roll_deg, pitch_deg, yaw_deg, input ready);
  modport sink (input valid, roll_deg, pitch_deg, yaw_deg, output ready);
endinterface

### src/ctf_cfg_if.sv
// Configuration write channel.
interface ctf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/imu_complementary_tilt_filter_core.sv
// Complementary tilt filter top level: registers, sequencing, blend and result register.
//
// Channels: in_ch takes one raw sample (three accelerometer axes, three gyro
// axes, delta_ms); out_ch gives roll and pitch in degrees Q9.16 and yaw in Q16.16;
// cfg_ch writes the six registers by index and is always ready.
// A sample is taken only while the block is idle. The result register loads
// once all five paths are done; the 48-step serial divider of the gyro
// increment is the slowest, with the 30-step square root plus the CORDIC
// (ATAN_ITERATIONS steps, capped at 24) running beside it; then come the S_RUN,
// S_MUL and S_SUM sequencing and blend states. Above 17 CORDIC steps the
// tilt path is the slowest instead.
// One sample is in work at a time; the next beat is accepted the cycle after
// the result reaches the output register.
// If the receiver stalls, the finished result waits in the output register;
// a later sample waits in its final blend step until that slot frees.
// Reset clears the roll, pitch and yaw state to zero and loads the default
// blend weight; offsets and biases reset to zero.
module imu_complementary_tilt_filter_core #(
  parameter int ATAN_ITERATIONS = 16
) (
  input logic       clk,
  input logic       rst_n,
  ctf_in_if.sink    in_ch,
  ctf_out_if.source out_ch,
  ctf_cfg_if.sink   cfg_ch
);

  localparam logic signed [39:0] ANG_MAX = 40'sd11796480;
  localparam logic signed [39:0] ANG_MIN = -40'sd11796480;
  localparam logic signed [34:0] YAW_MAX = 35'sd2147483647;
  localparam logic signed [34:0] YAW_MIN = -35'sd2147483648;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_MUL  = 4'b0100,
    S_SUM  = 4'b1000
  } top_state_t;

  top_state_t         state_r;
  logic [15:0]        blend_w_r;
  logic signed [23:0] roll_off_r, pitch_off_r;
  logic signed [15:0] bias_x_r, bias_y_r, bias_z_r;
  logic signed [24:0] roll_est_r, pitch_est_r;
  logic signed [31:0] yaw_r;
  logic               out_valid_r;
  logic signed [24:0] out_roll_r, out_pitch_r;
  logic signed [31:0] out_yaw_r;
  logic signed [51:0] rw_r, pw_r;
  logic signed [44:0] ra_r, pa_r;
  logic signed [34:0] yaw_sum_r;

  logic                 start;
  logic signed [16:0]   neg_ax;
  logic                 done_roll, done_pitch, done_x, done_y, done_z;
  ctf_pkg::tilt_angle_t ang_roll, ang_pitch;
  ctf_pkg::angle_inc_t  inc_x, inc_y, inc_z;
  logic signed [26:0]   acc_roll, acc_pitch;
  logic signed [34:0]   roll_prop, pitch_prop;
  logic signed [16:0]   w_s;
  logic signed [17:0]   w_c;
  logic signed [55:0]   roll_s, pitch_s;
  logic signed [39:0]   roll_q, pitch_q;
  logic signed [24:0]   roll_new, pitch_new;
  logic signed [31:0]   yaw_new;
  logic                 slot_free;

  assign start  = in_ch.valid && in_ch.ready;
  assign neg_ax = -$signed({in_ch.accel_x[15], in_ch.accel_x});

  ctf_tilt #(.ITERS(ATAN_ITERATIONS)) u_tilt_roll (
    .clk(clk), .rst_n(rst_n), .start(start),
    .num({in_ch.accel_y[15], in_ch.accel_y}),
    .a(in_ch.accel_x), .b(in_ch.accel_z),
    .done(done_roll), .angle(ang_roll)
  );

  ctf_tilt #(.ITERS(ATAN_ITERATIONS)) u_tilt_pitch (
    .clk(clk), .rst_n(rst_n), .start(start),
    .num(neg_ax), .a(in_ch.accel_y), .b(in_ch.accel_z),
    .done(done_pitch), .angle(ang_pitch)
  );

  ctf_rate u_rate_x (
    .clk(clk), .rst_n(rst_n), .start(start), .raw(in_ch.rate_x), .bias(bias_x_r),
    .dt(in_ch.delta_ms), .done(done_x), .inc(inc_x)
  );

  ctf_rate u_rate_y (
    .clk(clk), .rst_n(rst_n), .start(start), .raw(in_ch.rate_y), .bias(bias_y_r),
    .dt(in_ch.delta_ms), .done(done_y), .inc(inc_y)
  );

  ctf_rate u_rate_z (
    .clk(clk), .rst_n(rst_n), .start(start), .raw(in_ch.rate_z), .bias(bias_z_r),
    .dt(in_ch.delta_ms), .done(done_z), .inc(inc_z)
  );

  always_comb begin
    acc_roll   = ang_roll - roll_off_r;
    acc_pitch  = ang_pitch - pitch_off_r;
    roll_prop  = roll_est_r + inc_x;
    pitch_prop = pitch_est_r + inc_y;
    w_s        = $signed({1'b0, blend_w_r});
    w_c        = $signed(18'h10000 - {2'b00, blend_w_r});
    roll_s     = rw_r + ra_r + 56'sd32768;
    pitch_s    = pw_r + pa_r + 56'sd32768;
    roll_q     = roll_s[55:16];
    pitch_q    = pitch_s[55:16];

    if (roll_q > ANG_MAX)      roll_new = ANG_MAX[24:0];
    else if (roll_q < ANG_MIN) roll_new = ANG_MIN[24:0];
    else                       roll_new = roll_q[24:0];

    if (pitch_q > ANG_MAX)      pitch_new = ANG_MAX[24:0];
    else if (pitch_q < ANG_MIN) pitch_new = ANG_MIN[24:0];
    else                        pitch_new = pitch_q[24:0];

    if (yaw_sum_r > YAW_MAX)      yaw_new = YAW_MAX[31:0];
    else if (yaw_sum_r < YAW_MIN) yaw_new = YAW_MIN[31:0];
    else                          yaw_new = yaw_sum_r[31:0];

    slot_free = !out_valid_r || out_ch.ready;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_w_r   <= ctf_pkg::BLEND_WEIGHT_RESET;
      roll_off_r  <= '0;
      pitch_off_r <= '0;
      bias_x_r    <= '0;
      bias_y_r    <= '0;
      bias_z_r    <= '0;
    end else if (cfg_ch.valid) begin
      unique case (ctf_pkg::cfg_reg_t'(cfg_ch.index))
        ctf_pkg::REG_BLEND_WEIGHT: blend_w_r   <= cfg_ch.data[15:0];
        ctf_pkg::REG_ROLL_OFFSET:  roll_off_r  <= cfg_ch.data;
        ctf_pkg::REG_PITCH_OFFSET: pitch_off_r <= cfg_ch.data;
        ctf_pkg::REG_RATE_BIAS_X:  bias_x_r    <= cfg_ch.data[15:0];
        ctf_pkg::REG_RATE_BIAS_Y:  bias_y_r    <= cfg_ch.data[15:0];
        ctf_pkg::REG_RATE_BIAS_Z:  bias_z_r    <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      roll_est_r  <= '0;
      pitch_est_r <= '0;
      yaw_r       <= '0;
    end else begin
      if (state_r == S_SUM && slot_free) out_valid_r <= 1'b1;
      else if (out_ch.ready)             out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) state_r <= S_RUN;
        end
        S_RUN: begin
          if (done_roll && done_pitch && done_x && done_y && done_z) state_r <= S_MUL;
        end
        S_MUL: begin
          rw_r      <= roll_prop * w_s;
          pw_r      <= pitch_prop * w_s;
          ra_r      <= acc_roll * w_c;
          pa_r      <= acc_pitch * w_c;
          yaw_sum_r <= yaw_r + inc_z;
          state_r   <= S_SUM;
        end
        S_SUM: begin
          if (slot_free) begin
            roll_est_r  <= roll_new;
            pitch_est_r <= pitch_new;
            yaw_r       <= yaw_new;
            out_roll_r  <= roll_new;
            out_pitch_r <= pitch_new;
            out_yaw_r   <= yaw_new;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.roll_deg  = out_roll_r;
  assign out_ch.pitch_deg = out_pitch_r;
  assign out_ch.yaw_deg   = out_yaw_r;

endmodule

### src/ctf_tilt.sv
// Accelerometer tilt: squares, 2-bit-per-cycle square root, serial CORDIC arctangent.
module ctf_tilt #(
  parameter int ITERS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [16:0]   num,
  input  logic signed [15:0]   a,
  input  logic signed [15:0]   b,
  output logic                 done,
  output ctf_pkg::tilt_angle_t angle
);

  localparam int ITERS_EFF = (ITERS > ctf_pkg::ATAN_MAX_STEPS) ? ctf_pkg::ATAN_MAX_STEPS :
                             ((ITERS < 1) ? 1 : ITERS);
  localparam logic [4:0] LAST_ROT  = 5'(ITERS_EFF - 1);
  localparam logic [4:0] LAST_ROOT = 5'd29;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_ROOT = 5'b00100,
    ST_INIT = 5'b01000,
    ST_ROT  = 5'b10000
  } tilt_state_t;

  tilt_state_t        state_r;
  logic               done_r;
  logic signed [31:0] sqa_r, sqb_r;
  logic signed [16:0] num_r;
  logic [59:0]        n_r;
  logic [30:0]        rem_r;
  logic [29:0]        root_r;
  logic [4:0]         cnt_r;
  logic signed [33:0] x_r, y_r;
  logic signed [25:0] z_r;

  logic [32:0]        rem_t, trial, rem_sub;
  logic               ge;
  logic signed [33:0] dx, dy;
  logic signed [25:0] step_ang;

  always_comb begin
    rem_t    = {rem_r, n_r[59:58]};
    trial    = {1'b0, root_r, 2'b01};
    ge       = rem_t >= trial;
    rem_sub  = rem_t - trial;
    dx       = y_r >>> cnt_r;
    dy       = x_r >>> cnt_r;
    step_ang = ctf_pkg::atan_entry(cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            sqa_r   <= a * a;
            sqb_r   <= b * b;
            num_r   <= num;
            done_r  <= 1'b0;
            state_r <= ST_SUM;
          end
        end
        ST_SUM: begin
          n_r     <= {sqa_r + sqb_r, 28'b0};
          rem_r   <= '0;
          root_r  <= '0;
          cnt_r   <= '0;
          state_r <= ST_ROOT;
        end
        ST_ROOT: begin
          rem_r  <= ge ? rem_sub[30:0] : rem_t[30:0];
          root_r <= {root_r[28:0], ge};
          n_r    <= {n_r[57:0], 2'b00};
          cnt_r  <= cnt_r + 5'd1;
          if (cnt_r == LAST_ROOT) state_r <= ST_INIT;
        end
        ST_INIT: begin
          x_r   <= {4'b0, root_r};
          y_r   <= {{3{num_r[16]}}, num_r, 14'b0};
          z_r   <= '0;
          cnt_r <= '0;
          // zero vector: angle stays zero
          if (root_r == '0 && num_r == '0) begin
            done_r  <= 1'b1;
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_ROT;
          end
        end
        ST_ROT: begin
          if (y_r > 0) begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + step_ang;
          end else begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - step_ang;
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == LAST_ROT) begin
            done_r  <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign angle = z_r;

endmodule

### src/ctf_rate.sv
// Gyro angle increment: bias removal, rate*dt product, bit-serial divide by 65534.
module ctf_rate (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [15:0]  raw,
  input  logic signed [15:0]  bias,
  input  logic        [15:0]  dt,
  output logic                done,
  output ctf_pkg::angle_inc_t inc
);

  localparam logic [16:0] DIVISOR  = 17'd65534;
  localparam logic [5:0]  LAST_BIT = 6'd47;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_DIV  = 3'b100
  } rate_state_t;

  rate_state_t        state_r;
  logic               done_r;
  logic               neg_r;
  logic [15:0]        mag_r;
  logic [15:0]        dt_r;
  logic [47:0]        n_r;
  logic [15:0]        rem_r;
  logic [32:0]        q_r;
  logic [5:0]         cnt_r;

  logic signed [16:0] diff;
  logic [16:0]        diff_abs;
  logic [16:0]        rem_t, rem_sub;
  logic               ge;
  logic signed [33:0] q_s;

  always_comb begin
    diff     = raw - bias;
    diff_abs = diff[16] ? 17'(-diff) : 17'(diff);
    rem_t    = {rem_r, n_r[47]};
    ge       = rem_t >= DIVISOR;
    rem_sub  = rem_t - DIVISOR;
    q_s      = $signed({1'b0, q_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            neg_r   <= diff[16];
            mag_r   <= diff_abs[15:0];
            dt_r    <= dt;
            done_r  <= 1'b0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          // numerator p*65536 + 32767 rounds p*32768/32767 to nearest
          n_r     <= {32'(mag_r) * 32'(dt_r), 16'h7FFF};
          rem_r   <= '0;
          q_r     <= '0;
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r <= ge ? rem_sub[15:0] : rem_t[15:0];
          q_r   <= {q_r[31:0], ge};
          n_r   <= {n_r[46:0], 1'b0};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == LAST_BIT) begin
            done_r  <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign inc  = neg_r ? -q_s : q_s;

endmodule
